// ===== rtl/hmwc_pkg.sv =====
// ----------------------------------------------------------------------------
// hmwc_pkg
// Shared types and constants for the host mask width checker.
// ----------------------------------------------------------------------------
package hmwc_pkg;

  localparam int unsigned SymW     = 8;
  localparam int unsigned BitsW    = 6;
  localparam int unsigned DotsW    = 3;
  localparam int unsigned CfgDataW = 6;

  // Register indexes of the configuration port.
  typedef enum logic {
    REG_MIN_IP_BITS   = 1'b0,
    REG_MIN_HOST_DOTS = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    VERDICT_APPROVED    = 2'd0,
    VERDICT_OVERRIDABLE = 2'd1,
    VERDICT_REJECTED    = 2'd2
  } verdict_e;

  // Characters of interest.
  localparam logic [SymW-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [SymW-1:0] CHAR_STAR  = 8'h2A;
  localparam logic [SymW-1:0] CHAR_QUEST = 8'h3F;
  localparam logic [SymW-1:0] CHAR_SLASH = 8'h2F;
  localparam logic [SymW-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [SymW-1:0] CHAR_NINE  = 8'h39;

  localparam logic [BitsW-1:0] BitsPerField = 6'd8;
  localparam logic [BitsW-1:0] FullPrefix   = 6'd32;
  localparam logic [BitsW-1:0] BitsMax      = 6'd63;
  localparam logic [DotsW-1:0] QuadDots     = 3'd3;
  localparam logic [DotsW-1:0] DotMax       = 3'd7;

  // Scan state carried from one character to the next.
  typedef struct packed {
    logic             wild_last_field;
    logic             wild_prev_field;
    logic             has_wild;
    logic             still_ip;
    logic             suffix_mode;
    logic             rejected;
    logic [DotsW-1:0] dot_count;
    logic [BitsW-1:0] prefix_bits;
  } hmwc_state_t;

  localparam hmwc_state_t StateReset = '{
    wild_last_field: 1'b0,
    wild_prev_field: 1'b0,
    has_wild:        1'b0,
    still_ip:        1'b1,
    suffix_mode:     1'b0,
    rejected:        1'b0,
    dot_count:       '0,
    prefix_bits:     '0
  };

  // Add with saturation at the top of the prefix counter.
  function automatic logic [BitsW-1:0] add_sat(input logic [BitsW-1:0] a,
                                               input logic [BitsW-1:0] b);
    logic [BitsW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[BitsW] ? BitsMax : s[BitsW-1:0];
  endfunction

endpackage

// ===== rtl/hmwc_scan.sv =====
// ----------------------------------------------------------------------------
// hmwc_scan
// Scan state register, updated by one mask character per request.
// ----------------------------------------------------------------------------
module hmwc_scan (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      take_i,
  input  logic [hmwc_pkg::SymW-1:0] symbol_i,
  input  logic                      end_of_mask_i,
  output hmwc_pkg::hmwc_state_t     state_o
);
  import hmwc_pkg::*;

  hmwc_state_t st_q, st_d;
  logic        is_digit;
  logic [8:0]  suffix_val;

  assign is_digit   = (symbol_i >= CHAR_ZERO) && (symbol_i <= CHAR_NINE);
  // Digit value is the low nibble for '0' through '9'.
  assign suffix_val = {3'b000, st_q.prefix_bits} * 9'd10 + {5'b00000, symbol_i[3:0]};

  always_comb begin
    st_d = st_q;
    if (take_i) begin
      if (end_of_mask_i) begin
        st_d = StateReset;
      end else if (!st_q.rejected) begin
        if (st_q.suffix_mode) begin
          if (!is_digit) begin
            st_d.rejected = 1'b1;
          end else if (suffix_val > {3'b000, FullPrefix}) begin
            st_d.rejected    = 1'b1;
            st_d.prefix_bits = FullPrefix + 6'd1;
          end else begin
            st_d.prefix_bits = suffix_val[BitsW-1:0];
          end
        end else if (symbol_i == CHAR_DOT) begin
          st_d.wild_prev_field = st_q.wild_last_field;
          st_d.wild_last_field = 1'b0;
          if (st_q.dot_count != DotMax) begin
            st_d.dot_count = st_q.dot_count + 3'd1;
          end
          if (st_q.still_ip && !st_q.has_wild) begin
            st_d.prefix_bits = add_sat(st_q.prefix_bits, BitsPerField);
          end
        end else if (symbol_i == CHAR_STAR || symbol_i == CHAR_QUEST) begin
          st_d.wild_last_field = 1'b1;
          st_d.has_wild        = 1'b1;
        end else if (symbol_i == CHAR_SLASH) begin
          if (st_q.dot_count != QuadDots || !st_q.still_ip || st_q.has_wild) begin
            st_d.rejected = 1'b1;
          end else begin
            st_d.suffix_mode = 1'b1;
            st_d.prefix_bits = '0;
          end
        end else if (!is_digit) begin
          st_d.still_ip    = 1'b0;
          st_d.prefix_bits = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StateReset;
    end else begin
      st_q <= st_d;
    end
  end

  assign state_o = st_q;

endmodule

// ===== rtl/hmwc_judge.sv =====
// ----------------------------------------------------------------------------
// hmwc_judge
// Final verdict logic and the result register of the output channel.
// ----------------------------------------------------------------------------
module hmwc_judge (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  hmwc_pkg::hmwc_state_t      state_i,
  input  logic [hmwc_pkg::BitsW-1:0] min_ip_bits_i,
  input  logic [hmwc_pkg::DotsW-1:0] min_host_dots_i,
  input  logic                       take_i,
  output logic                       can_take_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 verdict_o
);
  import hmwc_pkg::*;

  logic             wild, ip;
  logic [BitsW-1:0] bits;
  verdict_e         verdict_d, verdict_q;
  logic             valid_q;

  always_comb begin
    wild = state_i.has_wild;
    ip   = state_i.still_ip;
    bits = state_i.prefix_bits;
    if (state_i.suffix_mode) begin
      // A '/' is only taken after exactly three dots, so the IP form holds.
      if (state_i.prefix_bits < FullPrefix) begin
        wild = 1'b1;
      end
    end else begin
      if (state_i.dot_count > QuadDots || (!wild && state_i.dot_count < QuadDots)) begin
        ip   = 1'b0;
        bits = '0;
      end
      if (ip && !wild) begin
        bits = add_sat(bits, BitsPerField);
      end
    end

    if (state_i.rejected) begin
      verdict_d = VERDICT_REJECTED;
    end else if (wild) begin
      if (!ip && (state_i.dot_count < min_host_dots_i || state_i.wild_last_field ||
                  state_i.wild_prev_field)) begin
        verdict_d = VERDICT_REJECTED;
      end else if (ip && bits < min_ip_bits_i) begin
        verdict_d = VERDICT_REJECTED;
      end else begin
        verdict_d = VERDICT_OVERRIDABLE;
      end
    end else begin
      verdict_d = VERDICT_APPROVED;
    end
  end

  assign can_take_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_take_o) begin
      valid_q <= take_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && can_take_o) begin
      verdict_q <= verdict_d;
    end
  end

  assign out_valid_o = valid_q;
  assign verdict_o   = verdict_q;

endmodule

// ===== rtl/host_mask_width_checker.sv =====
// ----------------------------------------------------------------------------
// host_mask_width_checker
// Streams a host mask one character per request and gives a verdict on the
// terminator request: approved, overridable or rejected.
// ----------------------------------------------------------------------------
// A terminator request accepted into the input register has its verdict
// captured in the result register once that register can take it.
// Throughput: one request per cycle. Only a terminator can wait, held in the
// input register while the result register keeps a verdict not yet taken.
// Reset: asynchronous, active low; clears the scan state, empties both
// pipeline registers and sets min_ip_bits to 16 and min_host_dots to 2.
module host_mask_width_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [hmwc_pkg::CfgDataW-1:0] cfg_wdata_i,
  // Input channel.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [hmwc_pkg::SymW-1:0]     symbol_i,
  input  logic                          end_of_mask_i,
  // Output channel.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    verdict_o
);
  import hmwc_pkg::*;

  // Configuration registers. The host dot threshold keeps the low three bits
  // of the write data.
  logic [BitsW-1:0] min_ip_bits_q;
  logic [DotsW-1:0] min_host_dots_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_ip_bits_q   <= 6'd16;
      min_host_dots_q <= 3'd2;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_MIN_IP_BITS) begin
        min_ip_bits_q <= cfg_wdata_i[BitsW-1:0];
      end else begin
        min_host_dots_q <= cfg_wdata_i[DotsW-1:0];
      end
    end
  end

  // Input register. A character leaves it as soon as it is seen, since it
  // only updates the scan state. A terminator leaves it only when the result
  // register can take its verdict, which is where backpressure from the
  // output channel reaches the input channel.
  logic            s1_valid_q;
  logic [SymW-1:0] s1_symbol_q;
  logic            s1_end_q;
  logic            s1_advance;
  logic            judge_can_take;
  logic            take_term;
  hmwc_state_t     scan_state;

  assign s1_advance = s1_valid_q && (!s1_end_q || judge_can_take);
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign take_term  = s1_advance && s1_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_symbol_q <= symbol_i;
      s1_end_q    <= end_of_mask_i;
    end
  end

  // The scan state updates in the same edge the verdict is captured, so the
  // verdict logic sees the state left by the last character of the mask.
  hmwc_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (s1_advance),
    .symbol_i      (s1_symbol_q),
    .end_of_mask_i (s1_end_q),
    .state_o       (scan_state)
  );

  hmwc_judge u_judge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .state_i         (scan_state),
    .min_ip_bits_i   (min_ip_bits_q),
    .min_host_dots_i (min_host_dots_q),
    .take_i          (take_term),
    .can_take_o      (judge_can_take),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .verdict_o       (verdict_o)
  );

endmodule

// ===== tb/mask_verdict_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mask_verdict_checker
// Watches the configuration port and both request channels of the host mask
// width checker, predicts the verdict of every mask and compares it with the
// verdict that the block returns.
// ----------------------------------------------------------------------------
module mask_verdict_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [hmwc_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [hmwc_pkg::SymW-1:0]     symbol_i,
  input  logic                          end_of_mask_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [1:0]                    verdict_i,
  output int unsigned                   mismatch_count_o,
  output int unsigned                   pending_o
);
  import hmwc_pkg::*;

  localparam hmwc_state_t ScanIdle = '{
    wild_last_field: 1'b0,
    wild_prev_field: 1'b0,
    has_wild:        1'b0,
    still_ip:        1'b1,
    suffix_mode:     1'b0,
    rejected:        1'b0,
    dot_count:       '0,
    prefix_bits:     '0
  };

  hmwc_state_t      scan_q;
  logic [BitsW-1:0] min_ip_bits_q;
  logic [DotsW-1:0] min_host_dots_q;
  verdict_e         expected_verdicts[$];
  int unsigned      mismatch_count;

  // One more fixed field of eight bits, held at the top of the counter.
  function automatic logic [BitsW-1:0] add_field_bits(input logic [BitsW-1:0] bits);
    logic [BitsW:0] sum;
    sum = {1'b0, bits} + {1'b0, BitsPerField};
    return sum[BitsW] ? BitsMax : sum[BitsW-1:0];
  endfunction

  function automatic hmwc_state_t scan_symbol(input hmwc_state_t s,
                                              input logic [SymW-1:0] c);
    logic       is_digit;
    logic [9:0] acc;
    is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    if (s.rejected) return s;
    if (s.suffix_mode) begin
      if (!is_digit) begin
        s.rejected = 1'b1;
      end else begin
        acc = 10'(s.prefix_bits) * 10'd10 + 10'(c - CHAR_ZERO);
        if (acc > 10'(FullPrefix)) begin
          s.rejected    = 1'b1;
          s.prefix_bits = FullPrefix + 1'b1;
        end else begin
          s.prefix_bits = acc[BitsW-1:0];
        end
      end
      return s;
    end
    if (c == CHAR_DOT) begin
      s.wild_prev_field = s.wild_last_field;
      s.wild_last_field = 1'b0;
      if (s.dot_count != DotMax) s.dot_count++;
      if (s.still_ip && !s.has_wild) s.prefix_bits = add_field_bits(s.prefix_bits);
    end else if (c == CHAR_STAR || c == CHAR_QUEST) begin
      s.wild_last_field = 1'b1;
      s.has_wild        = 1'b1;
    end else if (c == CHAR_SLASH) begin
      if (s.dot_count != QuadDots || !s.still_ip || s.has_wild) begin
        s.rejected = 1'b1;
      end else begin
        s.suffix_mode = 1'b1;
        s.prefix_bits = '0;
      end
    end else if (!is_digit) begin
      s.still_ip    = 1'b0;
      s.prefix_bits = '0;
    end
    return s;
  endfunction

  function automatic verdict_e rate_mask(input hmwc_state_t s);
    logic             wild;
    logic             ip;
    logic [BitsW-1:0] bits;
    wild = s.has_wild;
    ip   = s.still_ip;
    bits = s.prefix_bits;
    if (s.rejected) return VERDICT_REJECTED;
    if (s.suffix_mode) begin
      // A prefix length short of a full address acts like a wildcard.
      if (bits < FullPrefix) wild = 1'b1;
    end else begin
      if (s.dot_count > QuadDots || (!wild && s.dot_count < QuadDots)) begin
        ip   = 1'b0;
        bits = '0;
      end
      if (ip && !wild) bits = add_field_bits(bits);
    end
    if (!wild) return VERDICT_APPROVED;
    if (!ip && (s.dot_count < min_host_dots_q || s.wild_last_field || s.wild_prev_field))
      return VERDICT_REJECTED;
    if (ip && bits < min_ip_bits_q) return VERDICT_REJECTED;
    return VERDICT_OVERRIDABLE;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_e want;
    if (!rst_ni) begin
      scan_q          = ScanIdle;
      min_ip_bits_q   = 6'd16;
      min_host_dots_q = 3'd2;
      expected_verdicts.delete();
      mismatch_count  = 0;
    end else begin
      // A verdict passes the input and result registers after its terminator, so
      // checking before taking the new request never pairs it with its terminator.
      if (out_valid_i && out_ready_i) begin
        if (expected_verdicts.size() == 0) begin
          mismatch_count++;
          $error("verdict: expected none, got %0d", verdict_i);
        end else begin
          want = expected_verdicts.pop_front();
          if (verdict_i !== want) begin
            mismatch_count++;
            $error("verdict: expected %0d, got %0d", want, verdict_i);
          end
        end
      end
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_MIN_IP_BITS:   min_ip_bits_q   = cfg_wdata_i[BitsW-1:0];
          REG_MIN_HOST_DOTS: min_host_dots_q = cfg_wdata_i[DotsW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (end_of_mask_i) begin
          expected_verdicts.push_back(rate_mask(scan_q));
          scan_q = ScanIdle;
        end else begin
          scan_q = scan_symbol(scan_q, symbol_i);
        end
      end
    end
    mismatch_count_o <= mismatch_count;
    pending_o        <= expected_verdicts.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds host masks into the host mask width checker one character per
// request, with a short directed set followed by random masks of several
// shapes over a series of register settings. A checker module beside the
// block predicts every verdict; this top only drives and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import hmwc_pkg::*;

  // Six register settings; the last one runs without any idling.
  localparam int          NumPhases   = 6;
  localparam int          RandomPhase = 4;
  localparam int          PhaseItems  = 160;
  // The block passes a verdict through its input and result registers, so a
  // few quiet cycles are enough for anything still in flight to settle.
  localparam int          DrainCycles = 4;
  localparam logic [SymW-1:0] ChrLowerA = "a";
  localparam logic [SymW-1:0] ChrDash   = "-";

  // Planned settings per phase; phase zero keeps the reset values. The host
  // dot plan includes an all-ones write, which the block cuts to three bits.
  localparam logic [CfgDataW-1:0] IpBitsPlan   [NumPhases] = '{6'd16, 6'd0, 6'd32,
                                                             6'd63, 6'd0, 6'd24};
  localparam logic [CfgDataW-1:0] HostDotsPlan [NumPhases] = '{6'd2, 6'd0, 6'd7,
                                                             6'h3F, 6'd0, 6'd3};

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic                cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [SymW-1:0]     symbol_i;
  logic                end_of_mask_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [1:0]          verdict_o;

  int unsigned         mismatch_count;
  int unsigned         pending_verdicts;

  // Idling on both sides is allowed while this is set.
  bit                  stall_en;
  int                  items_sent;
  logic [SymW-1:0]     mask_chars[$];

  host_mask_width_checker u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .symbol_i      (symbol_i),
    .end_of_mask_i (end_of_mask_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .verdict_o     (verdict_o)
  );

  mask_verdict_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .symbol_i         (symbol_i),
    .end_of_mask_i    (end_of_mask_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .verdict_i        (verdict_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_verdicts)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // The receiver takes verdicts freely, except for random stalls while idling
  // is allowed. It owns out_ready_i alone.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_en && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  function automatic logic [SymW-1:0] rand_digit();
    return CHAR_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [SymW-1:0] rand_wild();
    return ($urandom_range(0, 1) == 0) ? CHAR_STAR : CHAR_QUEST;
  endfunction

  // Offers one request and holds it until the block takes it. Valid is only
  // lowered when a random gap is inserted; otherwise it stays high and the
  // next payload follows directly.
  task automatic send_symbol(input logic [SymW-1:0] sym, input logic last);
    if (stall_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    symbol_i      <= sym;
    end_of_mask_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // Sends the characters held in mask_chars, then a terminator whose symbol
  // is random since the block must ignore it.
  task automatic send_mask();
    foreach (mask_chars[i]) send_symbol(mask_chars[i], 1'b0);
    send_symbol(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic load_text(input string text);
    mask_chars.delete();
    foreach (text[i]) mask_chars.push_back(text[i]);
  endtask

  // Lets every verdict come back, then a few more cycles so that the block
  // is idle before the registers change.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_verdicts != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Each write holds the enable high for a single cycle and then lowers it, so
  // that back-to-back writes never touch the enable twice in one step.
  task automatic write_reg(input reg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Builds one random mask. Most masks are well formed, dotted addresses
  // with an optional prefix length or dotted host names, with wildcards
  // sprinkled in; the rest are long dotted runs that drive the dot and bit
  // counters into saturation, and plain noise over all byte values.
  task automatic build_mask();
    int kind;
    int fields;
    int len;
    mask_chars.delete();
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      fields = ($urandom_range(0, 3) != 0) ? 4 : $urandom_range(1, 6);
      for (int f = 0; f < fields; f++) begin
        if (f > 0) mask_chars.push_back(CHAR_DOT);
        if ($urandom_range(0, 5) == 0) mask_chars.push_back(rand_wild());
        else repeat ($urandom_range(1, 3)) mask_chars.push_back(rand_digit());
      end
      if ($urandom_range(0, 2) == 0) begin
        // A leading digit of 0 to 4 keeps the suffix near the limit of 32,
        // so short, full and too-wide prefix lengths all show up. An empty
        // suffix is allowed as well.
        mask_chars.push_back(CHAR_SLASH);
        len = $urandom_range(0, 2);
        if (len > 0) mask_chars.push_back(CHAR_ZERO + 8'($urandom_range(0, 4)));
        if (len > 1) mask_chars.push_back(rand_digit());
        if ($urandom_range(0, 7) == 0) mask_chars.push_back(8'($urandom_range(0, 255)));
      end
    end else if (kind < 7) begin
      fields = $urandom_range(1, 8);
      for (int f = 0; f < fields; f++) begin
        if (f > 0) mask_chars.push_back(CHAR_DOT);
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 7))
            0:       mask_chars.push_back(rand_wild());
            1:       mask_chars.push_back(rand_digit());
            2:       mask_chars.push_back(ChrDash);
            default: mask_chars.push_back(ChrLowerA + 8'($urandom_range(0, 25)));
          endcase
        end
      end
    end else if (kind == 7) begin
      fields = $urandom_range(7, 11);
      for (int f = 0; f < fields; f++) begin
        if (f > 0) mask_chars.push_back(CHAR_DOT);
        if ($urandom_range(0, 9) == 0) mask_chars.push_back(rand_wild());
        else mask_chars.push_back(rand_digit());
      end
    end else begin
      repeat ($urandom_range(0, 8)) begin
        case ($urandom_range(0, 5))
          0:       mask_chars.push_back(CHAR_DOT);
          1:       mask_chars.push_back(rand_wild());
          2:       mask_chars.push_back(CHAR_SLASH);
          3:       mask_chars.push_back(rand_digit());
          default: mask_chars.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_MIN_IP_BITS;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    symbol_i      = '0;
    end_of_mask_i = 1'b0;
    stall_en      = 1'b1;
    items_sent    = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        wait_idle();
        write_reg(REG_MIN_IP_BITS,
                  (p == RandomPhase) ? 6'($urandom_range(0, 63)) : IpBitsPlan[p]);
        write_reg(REG_MIN_HOST_DOTS,
                  (p == RandomPhase) ? 6'($urandom_range(0, 63)) : HostDotsPlan[p]);
      end
      stall_en <= (p != NumPhases - 1);

      if (p == 0) begin
        // An empty mask is not an address and has no wildcard.
        load_text("");
        send_mask();
        // A prefix length above 32 is rejected.
        load_text(".../33");
        send_mask();
        // A slash right before the terminator counts as a zero prefix.
        load_text(".../");
        send_mask();
        // A slash after a wildcard rejects, and the all-ones byte after it
        // is ignored.
        mask_chars = '{CHAR_STAR, CHAR_SLASH, 8'hFF};
        send_mask();
        // A zero byte is an ordinary character and does not end the mask.
        mask_chars = '{8'h00};
        send_mask();
        // Two fixed fields keep sixteen bits, enough for the reset setting.
        load_text("1.2.*");
        send_mask();
      end

      while (items_sent < (p + 1) * PhaseItems) begin
        build_mask();
        send_mask();
      end
    end

    wait_idle();
    if (mismatch_count == 0 && pending_verdicts == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // A correct run needs well under a tenth of this time.
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/hmwc_pkg.sv
rtl/hmwc_scan.sv
rtl/hmwc_judge.sv
rtl/host_mask_width_checker.sv
tb/mask_verdict_checker.sv
tb/testbench.sv
